### hdl/expression_token_scanner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the expression token scanner
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_SCANNER_ASSERT_SVH
`define EXPRESSION_TOKEN_SCANNER_ASSERT_SVH

// same-cycle implication
`define ETS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");

// next-cycle implication
`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");

`endif

### hdl/ets_pkg.sv
// ----------------------------------------------------------------------------
// Expression token scanner package
// Shared types and constants for the scanner step logic and result queue.
// ----------------------------------------------------------------------------
package ets_pkg;

	localparam int LENGTH_LIMIT = 255;
	localparam int LEN_W        = $clog2(LENGTH_LIMIT + 1);
	localparam int Q_DEPTH      = 4;
	localparam int Q_IDX_W      = $clog2(Q_DEPTH);
	localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_IDENT  = 3'd0,
		KIND_ARRAY  = 3'd1,
		KIND_NUMBER = 3'd2,
		KIND_SYMBOL = 3'd3,
		KIND_END    = 3'd4,
		KIND_ERROR  = 3'd5
	} kind_t;

	typedef enum logic [8:0] {
		M_IDLE      = 9'b000000001,
		M_NAME      = 9'b000000010,
		M_SPAN      = 9'b000000100,
		M_WHOLE     = 9'b000001000,
		M_FRAC      = 9'b000010000,
		M_DOT       = 9'b000100000,
		M_EXPMARK   = 9'b001000000,
		M_EXPSIGN   = 9'b010000000,
		M_EXPDIGITS = 9'b100000000
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] sym;
		logic [7:0] len;
		logic       last;
	} result_t;

	typedef struct packed {
		logic             v0;
		logic             v1;
		result_t          r0;
		result_t          r1;
		mode_t            mode;
		logic [LEN_W-1:0] len;
	} step_t;

endpackage

### hdl/ets_step.sv
// ----------------------------------------------------------------------------
// Scanner step logic
// Next scanner mode, token length and up to two results for one item.
// ----------------------------------------------------------------------------
module ets_step
	import ets_pkg::*;
(
	input  mode_t            mode,
	input  logic [LEN_W-1:0] len,
	input  logic [7:0]       char_code,
	input  logic             end_of_input,
	output step_t            step
);

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	typedef struct packed {
		logic             v;
		result_t          r;
		mode_t            mode;
		logic [LEN_W-1:0] len;
	} idle_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_exp(input logic [7:0] c);
		return c == CH_LOW_E || c == CH_UP_E;
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return c == 8'h3D || c == CH_PLUS || c == CH_MINUS || c == 8'h2A ||
			c == 8'h2F || c == 8'h25 || c == 8'h5E || c == 8'h28 ||
			c == 8'h29 || c == 8'h3B || c == 8'h3C || c == 8'h3E ||
			c == CH_LBRACK || c == CH_RBRACK || c == 8'h2C;
	endfunction

	function automatic logic [7:0] clamp_len(input logic [LEN_W-1:0] l);
		logic [15:0] w;
		w = 16'(l);
		return (w > 16'd255) ? 8'hFF : w[7:0];
	endfunction

	function automatic result_t mk(input kind_t k, input logic [7:0] s,
		input logic [LEN_W-1:0] l);
		result_t r;
		r.kind = k;
		r.sym  = s;
		r.len  = clamp_len(l);
		r.last = 1'b0;
		return r;
	endfunction

	function automatic idle_t scan_idle(input logic [7:0] c);
		idle_t t;
		t.v    = 1'b0;
		t.r    = mk(KIND_ERROR, c, LEN_W'(1));
		t.mode = M_IDLE;
		t.len  = '0;
		if (!is_space(c)) begin
			t.len = LEN_W'(1);
			if (is_alpha(c)) begin
				t.mode = M_NAME;
			end else if (is_digit(c)) begin
				t.mode = M_WHOLE;
			end else if (c == CH_DOT) begin
				t.mode = M_DOT;
			end else if (is_operator(c)) begin
				t.v   = 1'b1;
				t.r   = mk(KIND_SYMBOL, c, LEN_W'(1));
				t.len = '0;
			end else begin
				t.v   = 1'b1;
				t.len = '0;
			end
		end
		return t;
	endfunction

	logic             a_v;
	result_t          a_r;
	logic             b_v;
	result_t          b_r;
	mode_t            nx_mode;
	logic [LEN_W-1:0] nx_len;
	logic [LEN_W-1:0] len_g;
	idle_t            idl;

	assign len_g = (len < LEN_W'(LENGTH_LIMIT)) ? len + LEN_W'(1) : len;
	assign idl   = scan_idle(char_code);

	always_comb begin
		a_v     = 1'b0;
		a_r     = mk(KIND_IDENT, 8'h00, len);
		b_v     = 1'b0;
		b_r     = idl.r;
		nx_mode = mode;
		nx_len  = len;
		if (end_of_input) begin
			case (mode)
				M_NAME: begin
					a_v = 1'b1;
				end
				M_WHOLE, M_FRAC, M_EXPDIGITS: begin
					a_v = 1'b1;
					a_r = mk(KIND_NUMBER, 8'h00, len);
				end
				M_SPAN, M_DOT, M_EXPMARK, M_EXPSIGN: begin
					a_v = 1'b1;
					a_r = mk(KIND_ERROR, 8'h00, len);
				end
				default: begin
					a_v = 1'b0;
				end
			endcase
			b_v     = 1'b1;
			b_r     = mk(KIND_END, 8'h00, '0);
			nx_mode = M_IDLE;
			nx_len  = '0;
		end else begin
			case (mode)
				M_NAME: begin
					if (is_alpha(char_code) || is_digit(char_code)) begin
						nx_len = len_g;
					end else if (char_code == CH_LBRACK) begin
						nx_len  = len_g;
						nx_mode = M_SPAN;
					end else begin
						a_v     = 1'b1;
						b_v     = idl.v;
						nx_mode = idl.mode;
						nx_len  = idl.len;
					end
				end
				M_SPAN: begin
					nx_len = len_g;
					if (char_code == CH_RBRACK) begin
						a_v     = 1'b1;
						a_r     = mk(KIND_ARRAY, 8'h00, len_g);
						nx_mode = M_IDLE;
						nx_len  = '0;
					end
				end
				M_WHOLE, M_FRAC, M_EXPDIGITS: begin
					if (is_digit(char_code)) begin
						nx_len = len_g;
					end else if (char_code == CH_DOT && mode == M_WHOLE) begin
						nx_len  = len_g;
						nx_mode = M_FRAC;
					end else if (is_exp(char_code) && mode != M_EXPDIGITS) begin
						nx_len  = len_g;
						nx_mode = M_EXPMARK;
					end else begin
						a_v     = 1'b1;
						a_r     = mk(KIND_NUMBER, 8'h00, len);
						b_v     = idl.v;
						nx_mode = idl.mode;
						nx_len  = idl.len;
					end
				end
				M_DOT, M_EXPMARK, M_EXPSIGN: begin
					nx_len = len_g;
					if (is_digit(char_code)) begin
						nx_mode = (mode == M_DOT) ? M_FRAC : M_EXPDIGITS;
					end else if (mode == M_EXPMARK &&
						(char_code == CH_PLUS || char_code == CH_MINUS)) begin
						nx_mode = M_EXPSIGN;
					end else begin
						a_v     = 1'b1;
						a_r     = mk(KIND_ERROR, char_code, len_g);
						nx_mode = M_IDLE;
						nx_len  = '0;
					end
				end
				default: begin
					b_v     = idl.v;
					nx_mode = idl.mode;
					nx_len  = idl.len;
				end
			endcase
		end

		step.mode = nx_mode;
		step.len  = nx_len;
		step.v0   = a_v || b_v;
		step.v1   = a_v && b_v;
		step.r0   = a_v ? a_r : b_r;
		step.r1   = b_r;
		step.r0.last = !(a_v && b_v);
		step.r1.last = 1'b1;
	end

endmodule

### hdl/ets_outq.sv
// ----------------------------------------------------------------------------
// Scanner result queue
// Small queue taking up to two results per cycle and giving one per cycle.
// ----------------------------------------------------------------------------
module ets_outq
	import ets_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push0,
	input  logic               push1,
	input  result_t            din0,
	input  result_t            din1,
	input  logic               pop,
	output result_t            dout,
	output logic [Q_CNT_W-1:0] count
);

	result_t            mem_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] head_q;
	logic [Q_IDX_W-1:0] tail_q;
	logic [Q_CNT_W-1:0] count_q;
	logic [Q_CNT_W-1:0] n_push;

	assign n_push = Q_CNT_W'(push0) + Q_CNT_W'(push1);
	assign dout   = mem_q[head_q];
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[tail_q] <= din0;
		end
		if (push1) begin
			mem_q[tail_q + Q_IDX_W'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + n_push[Q_IDX_W-1:0];
			head_q  <= head_q + Q_IDX_W'(pop);
			count_q <= count_q + n_push - Q_CNT_W'(pop);
		end
	end

endmodule

### hdl/expression_token_scanner.sv
// ----------------------------------------------------------------------------
// Expression token scanner
// Lexes a character stream into identifier, array, number, symbol, end and
// error tokens, one character per cycle while the result queue has room.
//
//   channel  dir  tdata                               tuser / tlast
//   s_*      in   [7:0] char_code                     tuser[0] end_of_input
//   m_*      out  [2:0] kind [10:3] sym [18:11] len   tlast last_result
//
// One item enters the input register per cycle while the queue has room; its
// results are formed combinationally from it and written to a four-entry result queue.
// An item giving two results fills two queue entries, output one at a time; the input stalls
// when the queue lacks room for two more results.
// Accepted items pass through the input register and then the result queue.
// Reset leaves the scanner idle with zero length and the queue empty.
// ----------------------------------------------------------------------------
`include "expression_token_scanner_assert.svh"

module expression_token_scanner
	import ets_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] token_kind, [10:3] symbol_char, [18:11] token_length
	output logic        m_tlast
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               eoi_s1;
	mode_t              mode_q;
	logic [LEN_W-1:0]   len_q;
	step_t              step;
	logic               adv;
	logic               pop;
	result_t            head;
	logic [Q_CNT_W-1:0] count;
	logic [Q_CNT_W:0]   free_slots;

	assign pop        = m_tvalid && m_tready;
	assign free_slots = (Q_CNT_W + 1)'(Q_DEPTH) - (Q_CNT_W + 1)'(count) + (Q_CNT_W + 1)'(pop);
	assign adv        = valid_s1 && (free_slots >= (Q_CNT_W + 1)'(2));
	assign s_tready   = !valid_s1 || adv;

	ets_step u_step (
		.mode         (mode_q),
		.len          (len_q),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.step         (step)
	);

	ets_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (adv && step.v0),
		.push1  (adv && step.v1),
		.din0   (step.r0),
		.din1   (step.r1),
		.pop    (pop),
		.dout   (head),
		.count  (count)
	);

	assign m_tvalid = (count != '0);
	assign m_tdata  = {5'b0, head.len, head.sym, head.kind};
	assign m_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			len_q    <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				mode_q <= step.mode;
				len_q  <= step.len;
			end
		end
	end

	`ETS_ASSERT_NEXT(a_hold_s1, clk, arst_n, valid_s1 && !adv, valid_s1)
	`ETS_ASSERT_NOW(a_pair_last, clk, arst_n, adv && step.v1, step.r1.last && !step.r0.last)
	`ETS_ASSERT_NEXT(a_end_idle, clk, arst_n, adv && eoi_s1, mode_q == M_IDLE && len_q == '0)
	`ETS_ASSERT_NOW(a_q_bound, clk, arst_n, 1'b1, count <= Q_CNT_W'(Q_DEPTH))

endmodule
